### rtl/core/keyword_token_lexer_assert.svh
// ----------------------------------------------------------------------------
// Keyword token lexer assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_LEXER_ASSERT_SVH
`define KEYWORD_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ktl_pkg.sv
// ----------------------------------------------------------------------------
// Keyword token lexer package
// Kind codes, word tables, result type and the token classifier.
// ----------------------------------------------------------------------------
package ktl_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int PREFIX_DEPTH  = 10;
    localparam int LEN_W         = 8;
    localparam int PIDX_W        = $clog2(PREFIX_DEPTH);
    localparam int KIND_W        = 6;
    localparam int RESQ_DEPTH    = 4;
    localparam int RESQ_PTR_W    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W    = RESQ_PTR_W + 1;

    localparam logic [KIND_W-1:0] KIND_IDENT    = 6'd0;
    localparam logic [KIND_W-1:0] KIND_INT      = 6'd1;
    localparam logic [KIND_W-1:0] KIND_STRING   = 6'd2;
    localparam logic [KIND_W-1:0] KIND_KW_FIRST = 6'd3;
    localparam logic [KIND_W-1:0] KIND_WOP_FIRST = 6'd15;
    localparam logic [KIND_W-1:0] KIND_SOP_FIRST = 6'd18;
    localparam logic [KIND_W-1:0] KIND_COLON    = 6'd29;
    localparam logic [KIND_W-1:0] KIND_DOT      = 6'd30;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 6'd31;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 6'd32;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 6'd33;

    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_UNDER  = 8'd95;

    typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

    // Text is right-justified: the last character sits in the low byte.
    typedef struct packed {
        logic [PREFIX_DEPTH*8-1:0] text;
        logic [PIDX_W:0]           len;
    } word_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        logic              sat;
        logic              last;
    } result_t;

    localparam int N_KW  = 12;
    localparam int N_WOP = 3;
    localparam int N_SOP = 11;

    localparam word_t KEYWORDS [N_KW] = '{
        '{80'("jika"), 5'd4},     '{80'("untuk"), 5'd5},
        '{80'("dari"), 5'd4},     '{80'("ke"), 5'd2},
        '{80'("kembalikan"), 5'd10}, '{80'("fungsi"), 5'd6},
        '{80'("kerangka"), 5'd8}, '{80'("pakai"), 5'd5},
        '{80'("berhenti"), 5'd8}, '{80'("lanjut"), 5'd6},
        '{80'("Benar"), 5'd5},    '{80'("Salah"), 5'd5}
    };

    localparam word_t WORD_OPS [N_WOP] = '{
        '{80'("dan"), 5'd3}, '{80'("atau"), 5'd4}, '{80'("tidak"), 5'd5}
    };

    localparam word_t SYM_OPS [N_SOP] = '{
        '{80'("+"), 5'd1},  '{80'("-"), 5'd1},  '{80'("/"), 5'd1},
        '{80'("*"), 5'd1},  '{80'("="), 5'd1},  '{80'("=="), 5'd2},
        '{80'("!="), 5'd2}, '{80'(">"), 5'd1},  '{80'("<"), 5'd1},
        '{80'(">="), 5'd2}, '{80'("<="), 5'd2}
    };

    localparam word_t DOT_WORD = '{80'("."), 5'd1};

    function automatic logic word_match(input prefix_t p, input logic [LEN_W-1:0] len,
                                        input logic over, input word_t w);
        logic m;
        m = !over && (len == LEN_W'(w.len));
        for (int i = 0; i < PREFIX_DEPTH; i++)
        begin
            if (i < int'(w.len) && p[i] != w.text[(int'(w.len) - 1 - i) * 8 +: 8])
            begin
                m = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [KIND_W-1:0] classify(input prefix_t p,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic over, input logic ident,
                                                   input logic digits, input logic fq,
                                                   input logic lq);
        logic [KIND_W-1:0] kw_k;
        logic [KIND_W-1:0] wop_k;
        logic [KIND_W-1:0] sop_k;
        logic              kw_hit;
        logic              wop_hit;
        logic              sop_hit;
        logic [KIND_W-1:0] k;
        kw_k    = KIND_UNKNOWN;
        wop_k   = KIND_UNKNOWN;
        sop_k   = KIND_UNKNOWN;
        kw_hit  = 1'b0;
        wop_hit = 1'b0;
        sop_hit = 1'b0;
        for (int i = 0; i < N_KW; i++)
        begin
            if (!kw_hit && word_match(p, len, over, KEYWORDS[i]))
            begin
                kw_hit = 1'b1;
                kw_k   = KIND_KW_FIRST + KIND_W'(i);
            end
        end
        for (int i = 0; i < N_WOP; i++)
        begin
            if (!wop_hit && word_match(p, len, over, WORD_OPS[i]))
            begin
                wop_hit = 1'b1;
                wop_k   = KIND_WOP_FIRST + KIND_W'(i);
            end
        end
        for (int i = 0; i < N_SOP; i++)
        begin
            if (!sop_hit && word_match(p, len, over, SYM_OPS[i]))
            begin
                sop_hit = 1'b1;
                sop_k   = KIND_SOP_FIRST + KIND_W'(i);
            end
        end
        if (kw_hit)
            k = kw_k;
        else if (wop_hit)
            k = wop_k;
        else if (ident)
            k = KIND_IDENT;
        else if (digits)
            k = KIND_INT;
        else if (fq && lq)
            k = KIND_STRING;
        else if (sop_hit)
            k = sop_k;
        else if (word_match(p, len, over, DOT_WORD))
            k = KIND_DOT;
        else
            k = KIND_UNKNOWN;
        return k;
    endfunction

endpackage

### rtl/core/keyword_token_lexer.sv
// ----------------------------------------------------------------------------
// Keyword token lexer
// Splits a character stream into tokens and reports kind and length of each.
// ----------------------------------------------------------------------------
// One character (or line-end marker) is taken per clock cycle. Flags and the
// first ten characters of the pending token are updated in that cycle, and
// each finished token is classified in the same cycle and written into a
// four-entry result queue; results leave one per cycle while out_stall is
// low. A character can finish up to two tokens (a pending token and a
// bracket or colon), so input is stalled while fewer than two queue entries
// are free. A character that gives two results always follows one that gave
// none, so with the output side never stalled the queue holds at most two
// results and a character is taken every cycle; input stalls only once the
// output side holds off. Each result is registered in the queue first.
module keyword_token_lexer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   char_byte,
    input  logic                         line_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ktl_pkg::KIND_W-1:0]   token_kind,
    output logic [ktl_pkg::LEN_W-1:0]    token_length,
    output logic                         length_saturated,
    output logic                         last_of_run
);
    import ktl_pkg::*;

    prefix_t              prefix_reg;
    logic [LEN_W-1:0]     cur_len_reg,   cur_len_next;
    logic                 over_reg,      over_next;
    logic                 ident_reg,     ident_next;
    logic                 digits_reg,    digits_next;
    logic                 fq_reg,        fq_next;
    logic                 lq_reg,        lq_next;
    logic                 parity_reg,    parity_next;

    result_t              resq_reg [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] head_reg, head_next;
    logic [RESQ_PTR_W-1:0] tail_reg, tail_next;
    logic [RESQ_CNT_W-1:0] count_reg, count_next;

    logic                 in_fire;
    logic                 out_fire;
    logic                 is_ws;
    logic                 is_alpha;
    logic                 is_digit;
    logic                 is_delim;
    logic                 pending;
    logic                 do_flush;
    logic                 do_delim;
    logic                 do_append;
    logic                 flush_res;
    logic [KIND_W-1:0]    flush_kind;
    logic [KIND_W-1:0]    delim_kind;
    result_t              first_res;
    result_t              second_res;
    logic [1:0]           push_n;

    assign in_stall = (count_reg > RESQ_CNT_W'(RESQ_DEPTH - 2));
    assign in_fire  = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && !out_stall;

    assign token_kind       = resq_reg[head_reg].kind;
    assign token_length     = resq_reg[head_reg].length;
    assign length_saturated = resq_reg[head_reg].sat;
    assign last_of_run      = resq_reg[head_reg].last;

    always_comb
    begin
        is_ws    = (char_byte == 8'd32) || (char_byte inside {[8'd9:8'd13]});
        is_alpha = (char_byte inside {[8'd65:8'd90], [8'd97:8'd122]});
        is_digit = (char_byte inside {[8'd48:8'd57]});
        is_delim = (char_byte inside {CH_LPAREN, CH_RPAREN, CH_COLON});
        pending  = (cur_len_reg != '0);

        parity_next = parity_reg;
        do_flush    = 1'b0;
        do_delim    = 1'b0;
        do_append   = 1'b0;
        if (line_end)
        begin
            do_flush    = 1'b1;
            parity_next = 1'b0;
        end
        else
        begin
            parity_next = parity_reg ^ (char_byte == CH_QUOTE);
            if (is_ws && !parity_next)
                do_flush = 1'b1;
            else if (is_delim)
            begin
                do_flush = 1'b1;
                do_delim = 1'b1;
            end
            else
                do_append = 1'b1;
        end

        flush_res  = do_flush && pending;
        flush_kind = classify(prefix_reg, cur_len_reg, over_reg, ident_reg, digits_reg,
                              fq_reg, lq_reg);
        case (char_byte)
            CH_LPAREN: delim_kind = KIND_LPAREN;
            CH_RPAREN: delim_kind = KIND_RPAREN;
            default:   delim_kind = KIND_COLON;
        endcase

        second_res = '{kind: delim_kind, length: LEN_W'(1), sat: 1'b0, last: 1'b1};
        if (flush_res)
            first_res = '{kind: flush_kind, length: cur_len_reg, sat: over_reg,
                          last: !do_delim};
        else
            first_res = second_res;
        push_n = in_fire ? (2'(flush_res) + 2'(do_delim)) : 2'd0;

        cur_len_next = cur_len_reg;
        over_next    = over_reg;
        ident_next   = ident_reg;
        digits_next  = digits_reg;
        fq_next      = fq_reg;
        lq_next      = lq_reg;
        if (do_flush)
        begin
            cur_len_next = '0;
            over_next    = 1'b0;
            ident_next   = 1'b1;
            digits_next  = 1'b1;
            fq_next      = 1'b0;
            lq_next      = 1'b0;
        end
        else if (do_append)
        begin
            if (!pending)
            begin
                ident_next = is_alpha || (char_byte == CH_UNDER);
                fq_next    = (char_byte == CH_QUOTE);
            end
            else
                ident_next = ident_reg && (is_alpha || is_digit || (char_byte == CH_UNDER));
            digits_next = digits_reg && is_digit;
            lq_next     = (char_byte == CH_QUOTE);
            if (cur_len_reg < LEN_W'(MAX_TOKEN_LEN))
                cur_len_next = cur_len_reg + LEN_W'(1);
            else
                over_next = 1'b1;
        end

        tail_next  = tail_reg + RESQ_PTR_W'(push_n);
        head_next  = head_reg + RESQ_PTR_W'(out_fire);
        count_next = count_reg + RESQ_CNT_W'(push_n) - RESQ_CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_len_reg <= '0;
            over_reg    <= 1'b0;
            ident_reg   <= 1'b1;
            digits_reg  <= 1'b1;
            fq_reg      <= 1'b0;
            lq_reg      <= 1'b0;
            parity_reg  <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                cur_len_reg <= cur_len_next;
                over_reg    <= over_next;
                ident_reg   <= ident_next;
                digits_reg  <= digits_next;
                fq_reg      <= fq_next;
                lq_reg      <= lq_next;
                parity_reg  <= parity_next;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && do_append && (cur_len_reg < LEN_W'(PREFIX_DEPTH)))
            prefix_reg[cur_len_reg[PIDX_W-1:0]] <= char_byte;
        if (push_n != 2'd0)
            resq_reg[tail_reg] <= first_res;
        if (push_n == 2'd2)
            resq_reg[tail_reg + RESQ_PTR_W'(1)] <= second_res;
    end

endmodule

### rtl/core/ktl_checker.sv
// ----------------------------------------------------------------------------
// Keyword token lexer checker
// Port-level checks on the result channel and input stall, bound to the top
// level.
// ----------------------------------------------------------------------------
`include "keyword_token_lexer_assert.svh"

module ktl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ktl_pkg::KIND_W-1:0]   token_kind,
    input logic [ktl_pkg::LEN_W-1:0]    token_length,
    input logic                         length_saturated,
    input logic                         last_of_run
);
    import ktl_pkg::*;

    logic                        out_held;
    logic                        delim_out;
    logic                        delim_ok;
    logic                        len_full;
    logic [KIND_W+LEN_W+1:0]     out_word;

    assign out_held  = out_valid && out_stall;
    assign out_word  = {token_kind, token_length, length_saturated, last_of_run};
    assign delim_out = out_valid && (token_kind == KIND_LPAREN || token_kind == KIND_RPAREN ||
                                     token_kind == KIND_COLON);
    assign delim_ok  = (token_length == LEN_W'(1)) && !length_saturated && last_of_run;
    assign len_full  = (token_length == LEN_W'(MAX_TOKEN_LEN));

    `KTL_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled result changed")
    `KTL_ASSERT_NOW(a_kind_range, out_valid, token_kind <= KIND_UNKNOWN, "token kind out of range")
    `KTL_ASSERT_NOW(a_len_sat, out_valid && length_saturated, len_full, "saturated token short")
    `KTL_ASSERT_NOW(a_delim_shape, delim_out, delim_ok, "delimiter token malformed")
    `KTL_ASSERT_NOW(a_stall_busy, in_stall, out_valid, "input stalled with no result waiting")

endmodule

bind keyword_token_lexer ktl_checker u_ktl_checker (.*);
